@@ hw/rtl/vakf_pkg.sv @@
// Shared types and constants for the vector angle key filter.
// Used by vakf_cos and vector_angle_key_filter; depends on nothing else.
package vakf_pkg;

  typedef struct packed {
    logic [15:0] x;
    logic [15:0] y;
    logic [15:0] z;
  } vec_t;

  // One cosine result from the pair unit to the sequencer
  typedef struct packed {
    logic        valid;
    logic [16:0] cos;
  } cos_res_t;

  localparam int unsigned VectorCount = 5;
  localparam int unsigned StoreDepth  = VectorCount - 1;

  localparam logic [16:0] OneQ16 = 17'h10000;

  localparam logic [1:0] CfgCosThreshold = 2'd0;
  localparam logic [1:0] CfgRewardBase   = 2'd1;
  localparam logic [1:0] CfgRewardGain   = 2'd2;

  localparam logic [16:0] CosThresholdRst = 17'd15729;
  localparam logic [15:0] RewardBaseRst   = 16'd1000;
  localparam logic [15:0] RewardGainRst   = 16'd10000;

  // ceil(2^20 / 3): exact divide by three for values below 2^19
  localparam logic [18:0] RecipThree = 19'd349526;

endpackage

@@ hw/rtl/vakf_cos.sv @@
// Bit-serial pair cosine unit: dot and norms, norm product, square root, divide.
// Depends on vakf_pkg.
module vakf_cos (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  vakf_pkg::vec_t     a_i,
  input  vakf_pkg::vec_t     b_i,
  output vakf_pkg::cos_res_t res_o
);
  import vakf_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_MAC, S_MUL, S_SQRT, S_DIV} state_e;

  state_e     state_q;
  logic [5:0] cnt_q;
  vec_t       a_q, b_q, sa_q, sb_q;
  logic [33:0] dot_q, na_q, nb_q, mb_q, root_q;
  logic [33:0] dot_d, na_d, nb_d, root_d;
  logic [67:0] acc_q, acc_d;
  logic [34:0] rem_q, rem_sq_d, rem_dv_d;
  logic [36:0] rem_sh, trial, sq_diff;
  logic [35:0] dv_sh, dv_diff;
  logic        sq_ge, dv_ge;
  logic [16:0] nlow_q, quo_q, quo_d;
  cos_res_t    res_q;

  function automatic logic [33:0] tap(logic sel, logic [15:0] v);
    return sel ? {18'b0, v} : 34'b0;
  endfunction

  always_comb begin
    // MSB-first shift-add over the multiplier bits
    dot_d = {dot_q[32:0], 1'b0} + tap(sb_q.x[15], a_q.x) + tap(sb_q.y[15], a_q.y)
          + tap(sb_q.z[15], a_q.z);
    na_d  = {na_q[32:0], 1'b0} + tap(sa_q.x[15], a_q.x) + tap(sa_q.y[15], a_q.y)
          + tap(sa_q.z[15], a_q.z);
    nb_d  = {nb_q[32:0], 1'b0} + tap(sb_q.x[15], b_q.x) + tap(sb_q.y[15], b_q.y)
          + tap(sb_q.z[15], b_q.z);
    acc_d = {acc_q[66:0], 1'b0} + (mb_q[33] ? {34'b0, na_q} : 68'b0);

    // Restoring square root, two radicand bits per step
    rem_sh   = {rem_q, acc_q[67:66]};
    trial    = {1'b0, root_q, 2'b01};
    sq_ge    = rem_sh >= trial;
    sq_diff  = rem_sh - trial;
    rem_sq_d = sq_ge ? sq_diff[34:0] : rem_sh[34:0];
    root_d   = {root_q[32:0], sq_ge};

    // Restoring division, one quotient bit per step
    dv_sh    = {rem_q, nlow_q[16]};
    dv_ge    = dv_sh >= {2'b0, root_q};
    dv_diff  = dv_sh - {2'b0, root_q};
    rem_dv_d = dv_ge ? dv_diff[34:0] : dv_sh[34:0];
    quo_d    = {quo_q[15:0], dv_ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      res_q.valid <= 1'b0;
    end else begin
      res_q.valid <= 1'b0;
      case (state_q)
        S_IDLE: begin
          if (start_i) begin
            a_q     <= a_i;
            sa_q    <= a_i;
            b_q     <= b_i;
            sb_q    <= b_i;
            dot_q   <= '0;
            na_q    <= '0;
            nb_q    <= '0;
            cnt_q   <= 6'd15;
            state_q <= S_MAC;
          end
        end
        S_MAC: begin
          dot_q  <= dot_d;
          na_q   <= na_d;
          nb_q   <= nb_d;
          sa_q.x <= {sa_q.x[14:0], 1'b0};
          sa_q.y <= {sa_q.y[14:0], 1'b0};
          sa_q.z <= {sa_q.z[14:0], 1'b0};
          sb_q.x <= {sb_q.x[14:0], 1'b0};
          sb_q.y <= {sb_q.y[14:0], 1'b0};
          sb_q.z <= {sb_q.z[14:0], 1'b0};
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            mb_q    <= nb_d;
            acc_q   <= '0;
            cnt_q   <= 6'd33;
            state_q <= S_MUL;
          end
        end
        S_MUL: begin
          acc_q <= acc_d;
          mb_q  <= {mb_q[32:0], 1'b0};
          cnt_q <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            rem_q   <= '0;
            root_q  <= '0;
            cnt_q   <= 6'd33;
            state_q <= S_SQRT;
          end
        end
        S_SQRT: begin
          acc_q  <= {acc_q[65:0], 2'b00};
          rem_q  <= rem_sq_d;
          root_q <= root_d;
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            if (dot_q == '0 || root_d == '0) begin
              res_q.valid <= 1'b1;
              res_q.cos   <= OneQ16;
              state_q     <= S_IDLE;
            end else begin
              rem_q   <= {2'b00, dot_q[33:1]};
              nlow_q  <= {dot_q[0], 16'b0};
              quo_q   <= '0;
              cnt_q   <= 6'd16;
              state_q <= S_DIV;
            end
          end
        end
        S_DIV: begin
          rem_q  <= rem_dv_d;
          nlow_q <= {nlow_q[15:0], 1'b0};
          quo_q  <= quo_d;
          cnt_q  <= cnt_q - 6'd1;
          if (cnt_q == 6'd0) begin
            res_q.valid <= 1'b1;
            res_q.cos   <= (quo_d > OneQ16) ? OneQ16 : quo_d;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_o = res_q;

endmodule

@@ hw/rtl/vector_angle_key_filter.sv @@
// Top level of the vector angle key filter: vector store, pair sequencer, reward.
// Depends on vakf_pkg and vakf_cos.
//
// Usage: drive vec_x_i/vec_y_i/vec_z_i and raise start_i; a vector transfers at
// a rising edge with start_i high and busy_o low. The first four vectors of a
// key are stored, one per cycle, with busy_o staying low. The fifth starts the
// evaluation and busy_o rises until the result is out.
// Each of the four pair cosines runs through one shared bit-serial unit:
// dot/norm accumulation, norm product, square root and division (the division
// is skipped on a zero dot product or a zero root, giving a cosine of one).
// The pairs run one after another; the reward is then computed in the states
// ST_MUL, ST_SUB and ST_DIV3.
// The result (accepted_o, reward_o, max_cosine_o) is shown for one cycle with
// done_o high; the receiver takes it then and cannot stall it.
// Configuration writes (cfg_we_i, cfg_idx_i, cfg_wdata_i) take effect at once
// and belong in idle time. Reset empties the key and restores the register
// defaults; stored vectors keep no reset value.
module vector_angle_key_filter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [15:0] vec_x_i,
  input  logic [15:0] vec_y_i,
  input  logic [15:0] vec_z_i,
  input  logic        cfg_we_i,
  input  logic [1:0]  cfg_idx_i,
  input  logic [16:0] cfg_wdata_i,
  output logic        done_o,
  output logic        accepted_o,
  output logic [16:0] reward_o,
  output logic [16:0] max_cosine_o
);
  import vakf_pkg::*;

  typedef enum logic [2:0] {
    ST_LOAD, ST_GO, ST_WAIT, ST_MUL, ST_SUB, ST_DIV3
  } state_e;

  state_e      state_q;
  logic [2:0]  cnt_q;
  logic [1:0]  pair_q;
  vec_t        store_q [StoreDepth];
  vec_t        v4_q, vec_in, pa, pb;
  logic [16:0] thr_q, max_q;
  logic [15:0] base_q, gain_q;
  logic [18:0] sum_q, sum_d;
  logic        below_q, busy_q, done_q, acc_ok_q;
  logic [16:0] reward_q, maxo_q;
  logic [34:0] prod_q;
  logic [39:0] n_q, pos_part, neg_part;
  logic [16:0] bg_sum;
  logic [18:0] m3;
  logic [37:0] m3_mul;
  logic        cos_start;
  cos_res_t    cos_res;

  assign vec_in    = '{x: vec_x_i, y: vec_y_i, z: vec_z_i};
  assign cos_start = (state_q == ST_GO);

  // Pair order: (v0,v3) (v3,v2) (v2,v1) (v1,v4)
  always_comb begin
    case (pair_q)
      2'd0:    begin pa = store_q[0]; pb = store_q[3]; end
      2'd1:    begin pa = store_q[3]; pb = store_q[2]; end
      2'd2:    begin pa = store_q[2]; pb = store_q[1]; end
      default: begin pa = store_q[1]; pb = v4_q;       end
    endcase
  end

  vakf_cos u_cos (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(cos_start),
    .a_i    (pa),
    .b_i    (pb),
    .res_o  (cos_res)
  );

  always_comb begin
    sum_d    = sum_q + {2'b00, cos_res.cos};
    bg_sum   = {1'b0, base_q} + {1'b0, gain_q};
    // (base + gain) * 3 * 2^19 + 2^18 * 3
    pos_part = {3'b000, bg_sum, 20'b0} + {4'b0000, bg_sum, 19'b0} + 40'd786432;
    // gain * sum * 25
    neg_part = {1'b0, prod_q, 4'b0} + {2'b00, prod_q, 3'b0} + {5'b0, prod_q};
    m3       = n_q[37:19];
    m3_mul   = m3 * RecipThree;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
      cnt_q   <= '0;
      pair_q  <= '0;
      busy_q  <= 1'b0;
      done_q  <= 1'b0;
      thr_q   <= CosThresholdRst;
      base_q  <= RewardBaseRst;
      gain_q  <= RewardGainRst;
    end else begin
      done_q <= 1'b0;
      if (cfg_we_i) begin
        case (cfg_idx_i)
          CfgCosThreshold: thr_q  <= cfg_wdata_i;
          CfgRewardBase:   base_q <= cfg_wdata_i[15:0];
          CfgRewardGain:   gain_q <= cfg_wdata_i[15:0];
          default:         ;
        endcase
      end
      case (state_q)
        ST_LOAD: begin
          if (start_i) begin
            if (cnt_q < 3'(StoreDepth)) begin
              store_q[cnt_q[1:0]] <= vec_in;
              cnt_q <= cnt_q + 3'd1;
            end else begin
              v4_q    <= vec_in;
              cnt_q   <= '0;
              pair_q  <= '0;
              sum_q   <= '0;
              max_q   <= '0;
              below_q <= 1'b1;
              busy_q  <= 1'b1;
              state_q <= ST_GO;
            end
          end
        end
        ST_GO: state_q <= ST_WAIT;
        ST_WAIT: begin
          if (cos_res.valid) begin
            sum_q <= sum_d;
            if (cos_res.cos > max_q) max_q <= cos_res.cos;
            if (!(cos_res.cos < thr_q)) below_q <= 1'b0;
            if (pair_q == 2'd3) begin
              state_q <= ST_MUL;
            end else begin
              pair_q  <= pair_q + 2'd1;
              state_q <= ST_GO;
            end
          end
        end
        ST_MUL: begin
          prod_q   <= gain_q * sum_q;
          acc_ok_q <= below_q && (sum_q != '0);
          state_q  <= ST_SUB;
        end
        ST_SUB: begin
          n_q     <= pos_part - neg_part;
          state_q <= ST_DIV3;
        end
        ST_DIV3: begin
          // Negative totals saturate to zero
          done_q   <= 1'b1;
          maxo_q   <= max_q;
          reward_q <= (acc_ok_q && !n_q[39]) ? m3_mul[36:20] : 17'd0;
          busy_q   <= 1'b0;
          state_q  <= ST_LOAD;
        end
        default: state_q <= ST_LOAD;
      endcase
    end
  end

  assign busy_o       = busy_q;
  assign done_o       = done_q;
  assign accepted_o   = acc_ok_q;
  assign reward_o     = reward_q;
  assign max_cosine_o = maxo_q;

`ifndef SYNTHESIS
  a_single_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe held for two cycles");
  a_fifth_goes_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start_i && !busy_o && cnt_q == 3'(StoreDepth)) |=> busy_o)
    else $error("fifth vector did not start evaluation");
  a_reject_no_reward: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !accepted_o) |-> (reward_o == '0))
    else $error("reward given for rejected key");
  a_count_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= 3'(StoreDepth)) else $error("vector count out of range");
  a_done_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy_o) else $error("busy still high with result");
`endif

endmodule
